[design/osrm_pkg.sv]
package osrm_pkg;

    localparam int FRAME_WORDS = 4096;
    localparam int MEM_AW      = $clog2(FRAME_WORDS);
    localparam int MOVE_AW     = 28;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_MOVE  = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STRIDE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] addr;
        logic [31:0] data;
        logic        flag;
        logic        down;
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] sx;
        logic [12:0] sy;
        logic [12:0] dx;
        logic [12:0] dy;
    } t_cmd;

endpackage

[design/overlap_safe_rectangle_move.sv]
// Frame memory of 32-bit pixels with pixel write, pixel read and an overlap-safe
// rectangle move. A word is taken when start is high and busy is low; every word
// gives one result on o_done for exactly one cycle, in order, and the result
// cannot be held off. A write passes the front register and the queue, then o_done
// is registered; a read also passes the memory read register and S_RDWAIT. On a move
// of a clipped w x h rectangle, each row passes row offset, two stride multiplies,
// base adds and direction pick, moves one pixel per cycle over the single read
// and write port of the frame memory, then takes a row step. A two-word queue sits
// between the classifying front and the executing back, so start keeps being taken
// while a move runs until it fills.
// Configuration registers (0 width, 1 height, 2 stride) may only be written idle.
module overlap_safe_rectangle_move (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [11:0]         i_pixel_address,
    input  logic [31:0]         i_pixel_data,
    input  logic signed [12:0]  i_old_x,
    input  logic signed [12:0]  i_old_y,
    input  logic signed [12:0]  i_new_x,
    input  logic signed [12:0]  i_new_y,
    input  logic [12:0]         i_rect_width,
    input  logic [12:0]         i_rect_height,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [12:0]         i_cfg_wdata,
    output logic                o_done,
    output logic [31:0]         o_read_data,
    output logic [1:0]          o_status,
    output logic [12:0]         o_moved_width,
    output logic [12:0]         o_moved_height
);

    logic [12:0]       r_disp_w, r_disp_h, r_stride;
    logic              q_full, q_empty, q_push, q_pop;
    osrm_pkg::t_cmd    f_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= 13'd64;
            r_disp_h <= 13'd64;
            r_stride <= 13'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                osrm_pkg::REG_WIDTH:  r_disp_w <= i_cfg_wdata;
                osrm_pkg::REG_HEIGHT: r_disp_h <= i_cfg_wdata;
                osrm_pkg::REG_STRIDE: r_stride <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    osrm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (start && !busy),
        .i_mode          (i_mode),
        .i_pixel_address (i_pixel_address),
        .i_pixel_data    (i_pixel_data),
        .i_old_x         (i_old_x),
        .i_old_y         (i_old_y),
        .i_new_x         (i_new_x),
        .i_new_y         (i_new_y),
        .i_rect_width    (i_rect_width),
        .i_rect_height   (i_rect_height),
        .i_disp_w        (r_disp_w),
        .i_disp_h        (r_disp_h),
        .i_q_full        (q_full),
        .o_busy          (busy),
        .o_push          (q_push),
        .o_cmd           (f_cmd)
    );

    osrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    osrm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cmd          (q_cmd),
        .i_stride       (r_stride),
        .o_pop          (q_pop),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_status       (o_status),
        .o_moved_width  (o_moved_width),
        .o_moved_height (o_moved_height)
    );

endmodule

[design/osrm_front.sv]
module osrm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_mode,
    input  logic [11:0]          i_pixel_address,
    input  logic [31:0]          i_pixel_data,
    input  logic signed [12:0]   i_old_x,
    input  logic signed [12:0]   i_old_y,
    input  logic signed [12:0]   i_new_x,
    input  logic signed [12:0]   i_new_y,
    input  logic [12:0]          i_rect_width,
    input  logic [12:0]          i_rect_height,
    input  logic [12:0]          i_disp_w,
    input  logic [12:0]          i_disp_h,
    input  logic                 i_q_full,
    output logic                 o_busy,
    output logic                 o_push,
    output osrm_pkg::t_cmd       o_cmd
);

    function automatic logic signed [14:0] smax(input logic signed [14:0] a,
                                                input logic signed [14:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [14:0] smin(input logic signed [14:0] a,
                                                input logic signed [14:0] b);
        return (a < b) ? a : b;
    endfunction

    logic                  r_vld;
    osrm_pkg::t_cmd        r_cmd;
    osrm_pkg::t_cmd        n_cmd;
    logic signed [14:0]    ox, oy, nx, ny, dw, dh, rw, rh;
    logic signed [14:0]    left, top, right, bottom, sx, sy, dx, dy, cw, ch;

    always_comb begin
        ox = 15'(i_old_x);
        oy = 15'(i_old_y);
        nx = 15'(i_new_x);
        ny = 15'(i_new_y);
        dw = $signed({2'b00, i_disp_w});
        dh = $signed({2'b00, i_disp_h});
        rw = $signed({2'b00, i_rect_width});
        rh = $signed({2'b00, i_rect_height});
        left   = smax(15'sd0, smax(-ox, -nx));
        top    = smax(15'sd0, smax(-oy, -ny));
        right  = smin(rw, smin(dw - ox, dw - nx));
        bottom = smin(rh, smin(dh - oy, dh - ny));
        cw = right - left;
        ch = bottom - top;
        sx = ox + left;
        sy = oy + top;
        dx = nx + left;
        dy = ny + top;
        n_cmd.mode = i_mode;
        n_cmd.addr = i_pixel_address;
        n_cmd.data = i_pixel_data;
        n_cmd.down = ny > oy;
        n_cmd.w    = cw[12:0];
        n_cmd.h    = ch[12:0];
        n_cmd.sx   = sx[12:0];
        n_cmd.sy   = sy[12:0];
        n_cmd.dx   = dx[12:0];
        n_cmd.dy   = dy[12:0];
        // range flag for pixel access, empty flag for a move
        if (i_mode == osrm_pkg::MODE_MOVE) begin
            n_cmd.flag = (left >= right) || (top >= bottom);
        end else begin
            n_cmd.flag = ({{(osrm_pkg::MOVE_AW - 12){1'b0}}, i_pixel_address}
                          >= osrm_pkg::MOVE_AW'(osrm_pkg::FRAME_WORDS));
        end
    end

    assign o_push = r_vld && !i_q_full;
    assign o_busy = r_vld && i_q_full;
    assign o_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[design/osrm_queue.sv]
module osrm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  osrm_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output osrm_pkg::t_cmd       o_cmd
);

    osrm_pkg::t_cmd                  r_mem [osrm_pkg::QUEUE_DEPTH];
    logic [osrm_pkg::QUEUE_AW-1:0]   r_wp, r_rp;
    logic [osrm_pkg::QUEUE_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (osrm_pkg::QUEUE_AW + 1)'(osrm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[design/osrm_back.sv]
module osrm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  osrm_pkg::t_cmd       i_cmd,
    input  logic [12:0]          i_stride,
    output logic                 o_pop,
    output logic                 o_done,
    output logic [31:0]          o_read_data,
    output logic [1:0]           o_status,
    output logic [12:0]          o_moved_width,
    output logic [12:0]          o_moved_height
);

    typedef enum logic [2:0] {
        S_IDLE, S_RDWAIT, S_ROW, S_MUL, S_BASE, S_DIR, S_PIX, S_NEXT
    } t_state;

    localparam int AW = osrm_pkg::MOVE_AW;
    localparam int MW = osrm_pkg::MEM_AW;

    t_state              r_state;
    osrm_pkg::t_cmd      r_cmd;
    logic [12:0]         r_row, r_cnt, r_sy, r_dy;
    logic [25:0]         r_sp, r_dp;
    logic [AW-1:0]       r_sb, r_db, r_sa, r_da;
    logic                r_rev, r_err;
    logic                r_pv;
    logic [MW-1:0]       r_pa;
    logic [31:0]         r_rd;
    logic [31:0]         mem [osrm_pkg::FRAME_WORDS];

    logic                m_we, m_re;
    logic [MW-1:0]       m_wa, m_ra;
    logic [31:0]         m_wd;
    logic [AW-1:0]       head_addr;
    logic                src_ok, dst_ok, n_rev;
    logic [12:0]         yoff;

    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign head_addr = {{(AW - 12){1'b0}}, i_cmd.addr};
    assign src_ok    = r_sa < AW'(osrm_pkg::FRAME_WORDS);
    assign dst_ok    = r_da < AW'(osrm_pkg::FRAME_WORDS);
    assign yoff      = r_cmd.down ? (r_cmd.h - 13'd1 - r_row) : r_row;
    assign n_rev     = r_db > r_sb;

    always_comb begin
        m_we = r_pv;
        m_wa = r_pa;
        m_wd = r_rd;
        m_re = 1'b0;
        m_ra = r_sa[MW-1:0];
        if (o_pop && !i_cmd.flag && i_cmd.mode == osrm_pkg::MODE_WRITE) begin
            m_we = 1'b1;
            m_wa = head_addr[MW-1:0];
            m_wd = i_cmd.data;
        end
        if (o_pop && !i_cmd.flag && i_cmd.mode == osrm_pkg::MODE_READ) begin
            m_re = 1'b1;
            m_ra = head_addr[MW-1:0];
        end else if (r_state == S_PIX) begin
            m_re = src_ok;
        end
    end

    // write-first: a read of the word being written sees the new word
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_wa] <= m_wd;
        end
        if (m_re) begin
            r_rd <= (m_we && m_wa == m_ra) ? m_wd : mem[m_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_pv   <= (r_state == S_PIX) && src_ok && dst_ok;
            r_pa   <= r_da[MW-1:0];
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd          <= i_cmd;
                        o_read_data    <= '0;
                        o_moved_width  <= '0;
                        o_moved_height <= '0;
                        o_status       <= osrm_pkg::STATUS_DONE;
                        r_row          <= '0;
                        r_err          <= 1'b0;
                        case (i_cmd.mode)
                            osrm_pkg::MODE_WRITE: begin
                                o_done <= 1'b1;
                                if (i_cmd.flag) o_status <= osrm_pkg::STATUS_RANGE;
                            end
                            osrm_pkg::MODE_READ: begin
                                if (i_cmd.flag) begin
                                    o_done   <= 1'b1;
                                    o_status <= osrm_pkg::STATUS_RANGE;
                                end else begin
                                    r_state <= S_RDWAIT;
                                end
                            end
                            osrm_pkg::MODE_MOVE: begin
                                if (i_cmd.flag) begin
                                    o_done   <= 1'b1;
                                    o_status <= osrm_pkg::STATUS_EMPTY;
                                end else begin
                                    r_state <= S_ROW;
                                end
                            end
                            default: begin
                                o_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RDWAIT: begin
                    o_done      <= 1'b1;
                    o_read_data <= r_rd;
                    r_state     <= S_IDLE;
                end
                S_ROW: begin
                    r_sy    <= r_cmd.sy + yoff;
                    r_dy    <= r_cmd.dy + yoff;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sp    <= r_sy * i_stride;
                    r_dp    <= r_dy * i_stride;
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_sb    <= AW'(r_sp) + AW'(r_cmd.sx);
                    r_db    <= AW'(r_dp) + AW'(r_cmd.dx);
                    r_state <= S_DIR;
                end
                S_DIR: begin
                    // walk right to left when the row moves to higher addresses
                    r_rev   <= n_rev;
                    r_sa    <= n_rev ? r_sb + AW'(r_cmd.w) - 1'b1 : r_sb;
                    r_da    <= n_rev ? r_db + AW'(r_cmd.w) - 1'b1 : r_db;
                    r_cnt   <= r_cmd.w;
                    r_state <= S_PIX;
                end
                S_PIX: begin
                    if (!src_ok || !dst_ok) r_err <= 1'b1;
                    r_sa  <= r_rev ? r_sa - 1'b1 : r_sa + 1'b1;
                    r_da  <= r_rev ? r_da - 1'b1 : r_da + 1'b1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 13'd1) r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_row == r_cmd.h - 13'd1) begin
                        o_done         <= 1'b1;
                        o_status       <= r_err ? osrm_pkg::STATUS_RANGE
                                                : osrm_pkg::STATUS_DONE;
                        o_moved_width  <= r_cmd.w;
                        o_moved_height <= r_cmd.h;
                        r_state        <= S_IDLE;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_ROW;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == osrm_pkg::STATUS_EMPTY
        |-> o_moved_width == '0 && o_moved_height == '0)
        else $error("empty move reports a size");

    a_pix_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PIX |-> r_cnt != '0)
        else $error("pixel walk with no pixels left");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(r_state == S_PIX))
        else $error("pixel write without a preceding read");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_pop)
        else $error("queue popped while a word is in progress");

endmodule
